/* rtl/efq_pkg.sv */
// ----------------------------------------------------------------------------
// efq_pkg
// Operation and status codes, stream field layout and cell control type
// for the bounded event queue.
// ----------------------------------------------------------------------------
package efq_pkg;

    typedef enum logic [2:0] {
        FUNC_PUSH      = 3'd0,
        FUNC_POP       = 3'd1,
        FUNC_FLUSH     = 3'd2,
        FUNC_STATS_CLR = 3'd3,
        FUNC_SET_LIMIT = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_DROPPED   = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_LIMIT = 3'd3,
        STAT_BELOW_CNT = 3'd4
    } t_status;

    localparam int FUNC_BITS   = 3;
    localparam int STATUS_BITS = 3;
    localparam int HANDLE_W    = 16;
    localparam int LIMIT_W     = 7;
    localparam int OCC_W       = 7;
    localparam int CTR_W       = 32;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 128;

    // per-transfer command broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

/* rtl/efq_cell.sv */
// ----------------------------------------------------------------------------
// efq_cell
// One slot of the shifting queue. On pop it takes its upper neighbor's
// handle; on push it loads the new handle if it is the first free slot.
// ----------------------------------------------------------------------------
module efq_cell
    import efq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int HW    = 16
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  logic [HW-1:0]    i_handle,
    input  logic [HW-1:0]    i_next,
    output logic [HW-1:0]    o_data
);

    logic [HW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_data <= i_next;
        end else if (i_ctl.push && (i_count == CNT_W'(IDX))) begin
            r_data <= i_handle;
        end
    end

    assign o_data = r_data;

endmodule

/* rtl/bounded_event_fifo_with_drop_stats.sv */
// ----------------------------------------------------------------------------
// bounded_event_fifo_with_drop_stats
// Event handle queue with adjustable limit and wrapping transfer statistics.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit up)
// s_axis   in   tdata: event_handle[15:0], new_limit[22:16]; tuser: func[2:0]
// m_axis   out  tdata: popped_valid, popped_handle, occupancy, is_empty,
//                      enqueued_total, dequeued_total, dropped_total;
//               tuser: status[2:0]
//
// One transfer per cycle while s_axis_tready is high: each command is resolved
// in the cycle it is taken and its result lands in the output register on the
// next edge. The slots form a chain of cells, head in cell 0; pop shifts every
// cell down by one. s_axis_tready is high while the output register is free or
// being drained. Synchronous reset clears count, statistics and restores limit
// to CAPACITY; slot contents are not reset.
// ----------------------------------------------------------------------------
module bounded_event_fifo_with_drop_stats
    import efq_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // event_handle[15:0], new_limit[22:16], zero fill [23]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // func[2:0]
    input  logic [FUNC_BITS-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // popped_valid[0], popped_handle[16:1], occupancy[23:17], is_empty[24],
    // enqueued_total[56:25], dequeued_total[88:57], dropped_total[120:89],
    // zero fill [127:121]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // status[2:0]
    output logic [STATUS_BITS-1:0] m_axis_tuser
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int HW    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_limit, n_limit;
    logic [CTR_W-1:0] r_enq, n_enq;
    logic [CTR_W-1:0] r_deq, n_deq;
    logic [CTR_W-1:0] r_drop, n_drop;

    logic                   r_out_valid;
    logic [STATUS_BITS-1:0] r_out_user;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic                  in_fire;
    t_func                 func;
    logic [HANDLE_W-1:0]   in_handle;
    logic [LIMIT_W-1:0]    in_limit;
    logic [LW-1:0]         req_ext;
    t_status               status;
    logic                  pop_ok;
    logic [HANDLE_W-1:0]   popped;
    t_cell_ctl             ctl;
    logic [OUT_DATA_W-1:0] out_data;

    logic [HW-1:0] cell_q [CAPACITY+1];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign func          = t_func'(s_axis_tuser);
    assign in_handle     = s_axis_tdata[HANDLE_W-1:0];
    assign in_limit      = s_axis_tdata[HANDLE_W +: LIMIT_W];
    assign req_ext       = LW'(in_limit);

    always_comb begin
        n_count = r_count;
        n_limit = r_limit;
        n_enq   = r_enq;
        n_deq   = r_deq;
        n_drop  = r_drop;
        status  = STAT_OK;
        pop_ok  = 1'b0;
        ctl     = '0;
        unique case (func)
            FUNC_PUSH: begin
                if ((r_count >= r_limit) || (r_count >= CNT_W'(CAPACITY))) begin
                    n_drop = r_drop + 1'b1;
                    status = STAT_DROPPED;
                end else begin
                    ctl.push = in_fire;
                    n_count  = r_count + 1'b1;
                    n_enq    = r_enq + 1'b1;
                end
            end
            FUNC_POP: begin
                if (r_count == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    ctl.pop = in_fire;
                    pop_ok  = 1'b1;
                    n_count = r_count - 1'b1;
                    n_deq   = r_deq + 1'b1;
                end
            end
            FUNC_FLUSH: begin
                n_count = '0;
            end
            FUNC_STATS_CLR: begin
                n_enq  = '0;
                n_deq  = '0;
                n_drop = '0;
            end
            FUNC_SET_LIMIT: begin
                if ((req_ext == '0) || (req_ext > LW'(CAPACITY))) begin
                    status = STAT_BAD_LIMIT;
                end else if (req_ext < LW'(r_count)) begin
                    status = STAT_BELOW_CNT;
                end else begin
                    n_limit = CNT_W'(req_ext);
                end
            end
            default: begin
                // undefined opcodes leave state untouched
            end
        endcase
    end

    // chain of slots; cell_q[CAPACITY] feeds zeros into the top cell
    assign cell_q[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        efq_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .HW    (HW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_count  (r_count),
            .i_handle (in_handle[HW-1:0]),
            .i_next   (cell_q[g+1]),
            .o_data   (cell_q[g])
        );
    end

    always_comb begin
        popped = '0;
        if (pop_ok) begin
            popped[HW-1:0] = cell_q[0];
        end
        out_data         = '0;
        out_data[0]      = pop_ok;
        out_data[16:1]   = popped;
        out_data[23:17]  = OCC_W'(n_count);
        out_data[24]     = (n_count == '0);
        out_data[56:25]  = n_enq;
        out_data[88:57]  = n_deq;
        out_data[120:89] = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit     <= CNT_W'(CAPACITY);
            r_enq       <= '0;
            r_deq       <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_limit     <= n_limit;
                r_enq       <= n_enq;
                r_deq       <= n_deq;
                r_drop      <= n_drop;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_user <= status;
            r_out_data <= out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_limit)
        else $error("queue count above limit");

    a_limit_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_limit != '0) && (r_limit <= CNT_W'(CAPACITY)))
        else $error("limit out of legal range");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (func == FUNC_PUSH) && (r_count < r_limit)
        |=> (r_count == $past(r_count) + 1'b1) && (r_enq == $past(r_enq) + 1'b1))
        else $error("accepted push did not grow queue");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (func == FUNC_POP) && (r_count != '0)
        |=> m_axis_tvalid && m_axis_tdata[0] && (r_deq == $past(r_deq) + 1'b1))
        else $error("pop of non-empty queue did not deliver a handle");
`endif

endmodule
